/* design/date_to_epoch_seconds_core_assert.svh */
// assertion macros for the date to epoch seconds core
// no dependencies; included by modules that carry assertions
`ifndef DATE_TO_EPOCH_SECONDS_CORE_ASSERT_SVH
`define DATE_TO_EPOCH_SECONDS_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define DTE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dte assertion failed");
`define DTE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dte assertion failed");
`else
`define DTE_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* design/dte_pkg.sv */
// shared types, constants and calendar tables for the date to epoch core
// no dependencies
package dte_pkg;

  localparam int YEAR_W = 14;
  localparam int OPND_W = 13;
  localparam int QUOT_W = 7;

  localparam logic [OPND_W-1:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;
  localparam logic [YEAR_W-1:0] LEAP_BIAS = 14'd4000;
  localparam logic signed [YEAR_W-1:0] EPOCH_YEAR = 14'sd1970;
  localparam logic signed [YEAR_W-1:0] YEAR_BASE = 14'sd1900;
  localparam logic [31:0] DAY_SECONDS = 32'd86400;
  localparam logic [20:0] LEAPS_BEFORE_EPOCH = 21'd477;

  typedef struct packed {
    logic [QUOT_W-1:0] q;
    logic              rem_zero;
    logic              mult4;
  } div_res_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic leap, input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    if (leap && mon >= 4'd2) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

/* design/dte_div100.sv */
// shared divide-by-100 unit: reciprocal multiply, registered quotient
// depends on dte_pkg
module dte_div100 import dte_pkg::*; (
  input  logic              clk,
  input  logic [OPND_W-1:0] operand,
  output div_res_t          res
);

  logic [OPND_W-1:0]   op_r;
  logic [QUOT_W-1:0]   q_r;
  logic [2*OPND_W-1:0] prod;

  assign prod = operand * RECIP_100;

  always_ff @(posedge clk) begin
    op_r <= operand;
    q_r  <= prod[RECIP_SHIFT +: QUOT_W];
  end

  assign res.q        = q_r;
  assign res.rem_zero = ((OPND_W'(q_r) * OPND_W'(100)) == op_r);
  assign res.mult4    = (op_r[1:0] == 2'b00);

endmodule

/* design/date_to_epoch_seconds_core.sv */
// date to epoch seconds core: normalizes a calendar date and counts seconds
// depends on dte_pkg, dte_div100 and date_to_epoch_seconds_core_assert.svh
//
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------------
// input     | in        | start & !busy        | year month day hour minute second
// result    | out       | done (one cycle)     | epoch_seconds before_epoch norm_*
// config    | in        | cfg_we               | cfg_wdata (zone offset)
//
// one transaction walks S_LEAP, S_LEAP2 and S_ADJ, then S_QN, S_SUM1, S_SUM2,
// S_MUL and S_FIN; a year before the epoch finishes from S_ADJ. each month step
// of the day carry repeats S_ADJ, each year change reruns S_LEAP and S_LEAP2
// on the div-by-100 unit. busy is high from accept until the done cycle; a new
// transaction may start in the done cycle. rst is synchronous and clears the sequencer and offset.
// the receiver cannot stall: done is a single-cycle strobe
`include "date_to_epoch_seconds_core_assert.svh"

module date_to_epoch_seconds_core import dte_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] year,
  input  logic [3:0]  month,
  input  logic [5:0]  day,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [5:0]  second,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  output logic        done,
  output logic [31:0] epoch_seconds,
  output logic        before_epoch,
  output logic [8:0]  norm_year_offset,
  output logic [3:0]  norm_month,
  output logic [4:0]  norm_day,
  output logic [4:0]  norm_hour,
  output logic [5:0]  norm_minute,
  output logic [5:0]  norm_second
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LEAP  = 4'd1;
  localparam logic [3:0] S_LEAP2 = 4'd2;
  localparam logic [3:0] S_ADJ   = 4'd3;
  localparam logic [3:0] S_QN    = 4'd4;
  localparam logic [3:0] S_SUM1  = 4'd5;
  localparam logic [3:0] S_SUM2  = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]               state;
  logic [16:0]              zone;
  logic signed [YEAR_W-1:0] yr;
  logic [3:0]               mon;
  logic signed [7:0]        dcount;
  logic [4:0]               hr;
  logic [5:0]               mi;
  logic [5:0]               se;
  logic                     leap;
  logic [20:0]              days_a;
  logic [20:0]              leap_term;
  logic [20:0]              days;
  logic [16:0]              sod;
  logic [31:0]              acc;

  logic                     accept;
  logic [OPND_W-1:0]        div_op;
  div_res_t                 div_res;
  logic [4:0]               cur_len;
  logic [4:0]               prev_len;
  logic [OPND_W-1:0]        yr_m1;
  logic [OPND_W-1:0]        yr_off;

  // input normalization
  logic       c_sec, c_min, c_hr;
  logic [5:0] sec_n;
  logic [6:0] min_s;
  logic [5:0] min_n;
  logic [5:0] hr_s;
  logic [4:0] hr_n;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  assign c_sec = (second >= 6'd60);
  assign sec_n = c_sec ? second - 6'd60 : second;
  assign min_s = {1'b0, minute} + 7'(c_sec);
  assign c_min = (min_s >= 7'd60);
  assign min_n = 6'(c_min ? min_s - 7'd60 : min_s);
  assign hr_s  = {1'b0, hour} + 6'(c_min);
  assign c_hr  = (hr_s >= 6'd24);
  assign hr_n  = 5'(c_hr ? hr_s - 6'd24 : hr_s);

  assign yr_m1  = OPND_W'(yr - 14'sd1);
  assign yr_off = OPND_W'(yr - EPOCH_YEAR);
  assign div_op = (state == S_LEAP) ? OPND_W'(yr + LEAP_BIAS) : yr_m1;

  dte_div100 u_div (
    .clk     (clk),
    .operand (div_op),
    .res     (div_res)
  );

  assign cur_len  = month_len(leap, mon);
  assign prev_len = month_len(leap, mon - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (cfg_we) begin
      zone <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_LEAP;
          end
        end
        S_LEAP:  state <= S_LEAP2;
        S_LEAP2: state <= S_ADJ;
        S_ADJ: begin
          if (dcount[7]) begin
            if (mon == 4'd0) begin
              state <= S_LEAP;
            end
          end else if (dcount[6:0] >= 7'(cur_len)) begin
            if (mon == 4'd11) begin
              state <= S_LEAP;
            end
          end else if (yr < EPOCH_YEAR) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_QN;
          end
        end
        S_QN:   state <= S_SUM1;
        S_SUM1: state <= S_SUM2;
        S_SUM2: state <= S_MUL;
        S_MUL:  state <= S_FIN;
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          se     <= sec_n;
          mi     <= min_n;
          hr     <= hr_n;
          dcount <= $signed({2'b00, day}) + $signed(8'(c_hr)) - 8'sd1;
          if (month == 4'd0) begin
            mon <= 4'd11;
            yr  <= $signed({2'b00, year}) - 14'sd1;
          end else if (month >= 4'd13) begin
            mon <= month - 4'd13;
            yr  <= $signed({2'b00, year}) + 14'sd1;
          end else begin
            mon <= month - 4'd1;
            yr  <= $signed({2'b00, year});
          end
        end
      end
      S_LEAP2: begin
        leap <= div_res.mult4 && (!div_res.rem_zero || div_res.q[1:0] == 2'b00);
      end
      S_ADJ: begin
        if (dcount[7]) begin
          if (mon == 4'd0) begin
            mon    <= 4'd11;
            yr     <= yr - 14'sd1;
            dcount <= dcount + 8'sd31;
          end else begin
            mon    <= mon - 4'd1;
            dcount <= dcount + $signed({3'b000, prev_len});
          end
        end else if (dcount[6:0] >= 7'(cur_len)) begin
          dcount <= dcount - $signed({3'b000, cur_len});
          if (mon == 4'd11) begin
            mon <= 4'd0;
            yr  <= yr + 14'sd1;
          end else begin
            mon <= mon + 4'd1;
          end
        end else begin
          before_epoch <= (yr < EPOCH_YEAR);
          if (yr < EPOCH_YEAR) begin
            epoch_seconds <= '1;
          end
        end
      end
      S_SUM1: begin
        days_a <= 21'(yr_off) * 21'd365 + 21'(days_before(leap, mon))
                + 21'(dcount[6:0]);
        leap_term <= 21'(yr_m1[OPND_W-1:2]) - 21'(div_res.q)
                   + 21'(div_res.q[QUOT_W-1:2]) - LEAPS_BEFORE_EPOCH;
        sod <= 17'(hr) * 17'd3600 + 17'(mi) * 17'd60 + 17'(se);
      end
      S_SUM2: days <= days_a + leap_term;
      S_MUL:  acc  <= 32'({11'b0, days} * DAY_SECONDS);
      S_FIN: begin
        epoch_seconds <= acc + 32'(sod) + {{15{zone[16]}}, zone};
      end
      default: begin
      end
    endcase
  end

  assign norm_year_offset = 9'(yr - YEAR_BASE);
  assign norm_month       = mon;
  assign norm_day         = 5'(dcount + 8'sd1);
  assign norm_hour        = hr;
  assign norm_minute      = mi;
  assign norm_second      = se;

  `DTE_ASSERT_IMP(a_done_not_busy, clk, rst, done, !busy)
  `DTE_ASSERT_NXT(a_accept_busy, clk, rst, accept, busy)
  `DTE_ASSERT_IMP(a_before_all_ones, clk, rst, done && before_epoch, epoch_seconds == '1)
  `DTE_ASSERT_IMP(a_norm_ranges, clk, rst, done, norm_month < 4'd12 && norm_day != 5'd0)
  `DTE_ASSERT_IMP(a_time_ranges, clk, rst, done, norm_hour < 5'd24 && norm_minute < 6'd60)

endmodule

/* verif/date_to_epoch_seconds_core_test.sv */
// self-checking testbench for date_to_epoch_seconds_core: directed and random dates
// under several zone offsets, each result checked against an in-bench calendar model
// depends only on the date_to_epoch_seconds_core rtl and its package
`timescale 1ns / 1ps

module date_to_epoch_seconds_core_test;

  localparam int IDLE_LIMIT = 4000;
  localparam int MISMATCH_PRINT_MAX = 100;
  localparam int EPOCH_YEAR = 1970;
  localparam int BASE_YEAR = 1900;
  localparam longint SECONDS_PER_DAY = 86400;
  localparam int DAYS_IN_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct {
    bit        is_zone;
    bit [16:0] zone;
    bit [11:0] yr;
    bit [3:0]  mo;
    bit [5:0]  dy;
    bit [4:0]  hr;
    bit [5:0]  mi;
    bit [5:0]  se;
  } job_t;

  typedef struct {
    bit [31:0] seconds;
    bit        early;
    bit [8:0]  year_offset;
    bit [3:0]  month_idx;
    bit [4:0]  day_of_month;
    bit [4:0]  hh;
    bit [5:0]  mm;
    bit [5:0]  ss;
  } stamp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] year = '0;
  logic [3:0]  month = '0;
  logic [5:0]  day = '0;
  logic [4:0]  hour = '0;
  logic [5:0]  minute = '0;
  logic [5:0]  second = '0;
  logic        cfg_we = 1'b0;
  logic [16:0] cfg_wdata = '0;
  logic        done;
  logic [31:0] epoch_seconds;
  logic        before_epoch;
  logic [8:0]  norm_year_offset;
  logic [3:0]  norm_month;
  logic [4:0]  norm_day;
  logic [4:0]  norm_hour;
  logic [5:0]  norm_minute;
  logic [5:0]  norm_second;

  job_t   pending_jobs[$];
  stamp_t expected_stamps[$];
  int     zone_now = 0;
  int     gap_left = 0;
  int     calm_left = 0;
  int     mismatches = 0;
  int     idle_cycles = 0;

  date_to_epoch_seconds_core i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .year             (year),
    .month            (month),
    .day              (day),
    .hour             (hour),
    .minute           (minute),
    .second           (second),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .done             (done),
    .epoch_seconds    (epoch_seconds),
    .before_epoch     (before_epoch),
    .norm_year_offset (norm_year_offset),
    .norm_month       (norm_month),
    .norm_day         (norm_day),
    .norm_hour        (norm_hour),
    .norm_minute      (norm_minute),
    .norm_second      (norm_second)
  );

  always #4 clk = ~clk;

  function automatic bit is_leap_year(int y);
    int u;
    u = y + 4000;
    return (u % 4 == 0) && ((u % 100 != 0) || (u % 400 == 0));
  endfunction

  function automatic int month_length(int y, int m);
    return DAYS_IN_MONTH[m] + ((m == 1 && is_leap_year(y)) ? 1 : 0);
  endfunction

  function automatic longint leap_years_through(longint n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic stamp_t convert_date(bit [11:0] yr_in, bit [3:0] mo_in, bit [5:0] dy_in,
                                          bit [4:0] hr_in, bit [5:0] mi_in, bit [5:0] se_in,
                                          int zone);
    stamp_t res;
    int     y, mo, dc, hr, mi, se;
    longint days, total;
    se = se_in;
    mi = int'(mi_in) + se / 60;
    se = se % 60;
    hr = int'(hr_in) + mi / 60;
    mi = mi % 60;
    dc = hr / 24;
    hr = hr % 24;
    y = yr_in;
    mo = int'(mo_in) - 1;
    if (mo < 0) begin
      mo = 11;
      y = y - 1;
    end else if (mo >= 12) begin
      mo = mo - 12;
      y = y + 1;
    end
    dc = dc + int'(dy_in) - 1;
    while (dc < 0) begin
      mo = mo - 1;
      if (mo < 0) begin
        mo = 11;
        y = y - 1;
      end
      dc = dc + month_length(y, mo);
    end
    while (dc >= month_length(y, mo)) begin
      dc = dc - month_length(y, mo);
      mo = mo + 1;
      if (mo == 12) begin
        mo = 0;
        y = y + 1;
      end
    end
    res.early = (y < EPOCH_YEAR);
    if (res.early) begin
      res.seconds = '1;
    end else begin
      days = longint'(y - EPOCH_YEAR) * 365 + leap_years_through(y - 1)
           - leap_years_through(EPOCH_YEAR - 1);
      for (int m = 0; m < mo; m++) begin
        days = days + month_length(y, m);
      end
      days = days + dc;
      total = days * SECONDS_PER_DAY + longint'((hr * 60 + mi) * 60 + se) + longint'(zone);
      res.seconds = total[31:0];
    end
    res.year_offset = 9'(y - BASE_YEAR);
    res.month_idx = 4'(mo);
    res.day_of_month = 5'(dc + 1);
    res.hh = 5'(hr);
    res.mm = 6'(mi);
    res.ss = 6'(se);
    return res;
  endfunction

  // mostly short gaps, a few long ones, and stretches with none
  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left = calm_left - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_date(int y, int mo, int d, int h, int mi, int s);
    job_t j;
    j.is_zone = 1'b0;
    j.zone = '0;
    j.yr = 12'(y);
    j.mo = 4'(mo);
    j.dy = 6'(d);
    j.hr = 5'(h);
    j.mi = 6'(mi);
    j.se = 6'(s);
    pending_jobs.push_back(j);
  endfunction

  function automatic void add_zone(int z);
    job_t j;
    j = '{default: '0};
    j.is_zone = 1'b1;
    j.zone = 17'(z);
    pending_jobs.push_back(j);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MISMATCH_PRINT_MAX) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : driver
    logic go;
    logic zone_we;
    go = start;
    zone_we = 1'b0;
    if (rst) begin
      gap_left = 0;
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_stamps.push_back(convert_date(year, month, day, hour, minute, second,
                                               zone_now));
        go = 1'b0;
        gap_left = next_gap();
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (pending_jobs.size() > 0) begin
          if (!pending_jobs[0].is_zone) begin
            year <= pending_jobs[0].yr;
            month <= pending_jobs[0].mo;
            day <= pending_jobs[0].dy;
            hour <= pending_jobs[0].hr;
            minute <= pending_jobs[0].mi;
            second <= pending_jobs[0].se;
            go = 1'b1;
            void'(pending_jobs.pop_front());
          end else if (!busy && !done && expected_stamps.size() == 0) begin
            // zone offset only changes while the block is idle
            cfg_wdata <= pending_jobs[0].zone;
            zone_now = $signed(pending_jobs[0].zone);
            zone_we = 1'b1;
            void'(pending_jobs.pop_front());
          end
        end
      end
      start <= go;
      cfg_we <= zone_we;
    end
  end

  always @(posedge clk) begin : monitor
    stamp_t want;
    if (!rst && done) begin
      if (expected_stamps.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with none expected, actual seconds %0d",
                 $time, epoch_seconds);
      end else begin
        want = expected_stamps.pop_front();
        check_field("epoch_seconds", want.seconds, epoch_seconds);
        check_field("before_epoch", want.early, before_epoch);
        check_field("norm_year_offset", want.year_offset, norm_year_offset);
        check_field("norm_month", want.month_idx, norm_month);
        check_field("norm_day", want.day_of_month, norm_day);
        check_field("norm_hour", want.hh, norm_hour);
        check_field("norm_minute", want.mm, norm_minute);
        check_field("norm_second", want.ss, norm_second);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int r;
    int y;
    int zone_pick;

    // directed dates under the reset offset
    add_date(1970, 1, 1, 0, 0, 0);
    add_date(1969, 12, 31, 23, 59, 59);
    add_date(1970, 1, 0, 0, 0, 0);
    add_date(2038, 1, 19, 3, 14, 7);
    add_date(2106, 2, 7, 6, 28, 15);
    add_date(2106, 2, 7, 6, 28, 16);
    add_date(2000, 2, 29, 12, 0, 0);
    add_date(1900, 2, 29, 0, 0, 0);
    add_date(2100, 3, 0, 0, 0, 0);
    add_date(2400, 2, 29, 23, 59, 59);
    add_date(2024, 0, 15, 0, 0, 0);
    add_date(2024, 13, 1, 0, 0, 0);
    add_date(2024, 14, 31, 0, 0, 0);
    add_date(2155, 15, 63, 31, 63, 63);
    add_date(2023, 12, 31, 23, 59, 60);
    add_date(1999, 1, 1, 0, 0, 63);
    add_date(2001, 6, 30, 31, 63, 63);
    add_date(0, 0, 0, 0, 0, 0);
    add_date(4095, 15, 63, 31, 63, 63);
    add_date(1899, 6, 15, 12, 30, 30);
    add_date(2020, 3, 0, 24, 0, 0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       zone_pick = -65536;
        1:       zone_pick = 65535;
        2:       zone_pick = -50400;
        3:       zone_pick = 50400;
        4:       zone_pick = 0;
        5:       zone_pick = $urandom_range(0, 100800) - 50400;
        default: zone_pick = $signed(17'($urandom));
      endcase
      add_zone(zone_pick);
      repeat (112) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          y = $urandom_range(1901, 2155);
        end else if (r < 60) begin
          y = $urandom_range(1967, 1972);
        end else if (r < 70) begin
          y = 400 * $urandom_range(4, 9) + 100 * $urandom_range(0, 3) + $urandom_range(0, 2) - 1;
        end else begin
          y = $urandom_range(0, 4095);
        end
        add_date(y,
                 ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(0, 15),
                 ($urandom_range(0, 9) < 7) ? $urandom_range(1, 31) : $urandom_range(0, 63),
                 ($urandom_range(0, 3) < 3) ? $urandom_range(0, 23) : $urandom_range(0, 31),
                 ($urandom_range(0, 3) < 3) ? $urandom_range(0, 59) : $urandom_range(0, 63),
                 ($urandom_range(0, 3) < 3) ? $urandom_range(0, 59) : $urandom_range(0, 63));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending_jobs.size() != 0 || start || expected_stamps.size() != 0);
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
